// ===== rtl/mpct_pkg.sv =====
// Shared constants and types for the mouse packet cursor tracker.
// No dependencies; used by every module of the block.

package mpct_pkg;

    localparam int POS_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 32;
    localparam int BTN_W   = 3;
    localparam int MAG_W   = BYTE_W + 1;

    // Output beat: cursor_x, cursor_y, buttons, zero fill to whole bytes
    localparam int OUT_FIELDS_W = 2 * POS_W + BTN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LIMIT     = 2'd2;
    localparam int CFG_DATA_W = 16;

    // Packet modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_THREE = 2'd1;

    // Always-one status bit seen at its aligned place in the shift register
    localparam int MARK_THREE_BIT = 19;
    localparam int MARK_FOUR_BIT  = 27;

    // Status byte bits
    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

    localparam logic [POS_W-1:0] LIMIT_RESET = 16'd1024;

    // One axis movement: sign bit and low byte of a 9-bit two's complement value
    typedef struct packed {
        logic              neg;
        logic [BYTE_W-1:0] delta;
    } move_t;

endpackage

// ===== rtl/mouse_packet_cursor_tracker_core.sv =====
// Top level of the mouse packet cursor tracker: byte stream in, cursor beats out.
// Depends on mpct_pkg and mpct_axis_move.

// Takes one mouse byte per beat and keeps the cursor position. An accepted byte
// is held in an input register, is shifted into the packet register and,
// when the status byte lines up (3-byte packets in mode 1, 4-byte in modes 2
// and 3), moves the cursor and loads one result beat into the output register. A
// byte is taken every cycle while the output is free or being taken; the single
// update stage, which reads and writes the cursor in the same cycle, sets that
// rate. Mode 0 drops every byte. Write configuration only while no byte is in
// flight.
module mouse_packet_cursor_tracker_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mpct_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] data_byte
    // stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mpct_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [15:0] cursor_x,
                                                              // [31:16] cursor_y,
                                                              // [34:32] buttons,
                                                              // [39:35] zero
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mpct_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW = mpct_pkg::POS_W;

    logic                          in_valid_reg;
    logic [mpct_pkg::BYTE_W-1:0]   in_byte_reg;
    logic [mpct_pkg::SHIFT_W-1:0]  shift_reg;
    logic [mpct_pkg::SHIFT_W-1:0]  shift_next;
    logic [PW-1:0]                 pos_x_reg;
    logic [PW-1:0]                 pos_y_reg;
    logic [1:0]                    mode_reg;
    logic [PW-1:0]                 x_limit_reg;
    logic [PW-1:0]                 y_limit_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mpct_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                          out_free;
    logic                          fire;
    logic [mpct_pkg::SHIFT_W-1:0]  shifted;
    logic                          complete;
    logic [mpct_pkg::BYTE_W-1:0]   stat;
    mpct_pkg::move_t               mv_x;
    mpct_pkg::move_t               mv_y;
    logic [PW-1:0]                 new_x;
    logic [PW-1:0]                 new_y;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        shifted = {shift_reg[mpct_pkg::SHIFT_W-mpct_pkg::BYTE_W-1:0], in_byte_reg};
        if (mode_reg == mpct_pkg::MODE_THREE)
        begin
            complete   = shifted[mpct_pkg::MARK_THREE_BIT];
            stat       = shifted[23:16];
            mv_x.delta = shifted[15:8];
            mv_y.delta = shifted[7:0];
        end
        else
        begin
            complete   = shifted[mpct_pkg::MARK_FOUR_BIT];
            stat       = shifted[31:24];
            mv_x.delta = shifted[23:16];
            mv_y.delta = shifted[15:8];
        end
        if (mode_reg == mpct_pkg::MODE_OFF)
        begin
            complete = 1'b0;
        end
        mv_x.neg = stat[mpct_pkg::SIGN_X_BIT];
        mv_y.neg = stat[mpct_pkg::SIGN_Y_BIT];
    end

    mpct_axis_move u_move_x
    (
        .pos     (pos_x_reg),
        .mv      (mv_x),
        .invert  (1'b0),
        .limit   (x_limit_reg),
        .new_pos (new_x)
    );

    // Y runs the other way: negative movement moves the cursor down the screen
    mpct_axis_move u_move_y
    (
        .pos     (pos_y_reg),
        .mv      (mv_y),
        .invert  (1'b1),
        .limit   (y_limit_reg),
        .new_pos (new_y)
    );

    always_comb
    begin
        shift_next = shift_reg;
        if (fire)
        begin
            if (mode_reg == mpct_pkg::MODE_OFF || complete)
            begin
                shift_next = '0;
            end
            else
            begin
                shift_next = shifted;
            end
        end

        out_valid_next = out_valid_reg;
        if (fire && complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            shift_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            mode_reg      <= mpct_pkg::MODE_OFF;
            x_limit_reg   <= mpct_pkg::LIMIT_RESET;
            y_limit_reg   <= mpct_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
            if (fire && complete)
            begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mpct_pkg::REG_PACKET_MODE: mode_reg    <= cfg_data[1:0];
                    mpct_pkg::REG_X_LIMIT:     x_limit_reg <= cfg_data;
                    mpct_pkg::REG_Y_LIMIT:     y_limit_reg <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (fire && complete)
        begin
            out_data_reg <= {{(mpct_pkg::OUT_DATA_W - mpct_pkg::OUT_FIELDS_W){1'b0}},
                             stat[mpct_pkg::BTN_W-1:0], new_y, new_x};
        end
    end

endmodule

// ===== rtl/mpct_axis_move.sv =====
// Applies one signed movement to a cursor coordinate with saturation.
// Depends on mpct_pkg.

module mpct_axis_move
(
    input  logic [mpct_pkg::POS_W-1:0] pos,
    input  mpct_pkg::move_t            mv,
    input  logic                       invert,
    input  logic [mpct_pkg::POS_W-1:0] limit,
    output logic [mpct_pkg::POS_W-1:0] new_pos
);

    logic                         go_up;
    logic [mpct_pkg::MAG_W-1:0]   mag;
    logic [mpct_pkg::POS_W:0]     sum;
    logic [mpct_pkg::POS_W-1:0]   mag_ext;

    always_comb
    begin
        // positive moves add unless the axis is inverted
        go_up   = !(mv.neg ^ invert);
        // a negative move of zero with the sign set is a full 256 steps
        mag     = mv.neg ? (9'd256 - {1'b0, mv.delta}) : {1'b0, mv.delta};
        mag_ext = {{(mpct_pkg::POS_W - mpct_pkg::MAG_W){1'b0}}, mag};
        sum     = {1'b0, pos} + {1'b0, mag_ext};
        if (go_up)
        begin
            new_pos = (sum > {1'b0, limit}) ? limit : sum[mpct_pkg::POS_W-1:0];
        end
        else
        begin
            new_pos = (mag_ext > pos) ? '0 : (pos - mag_ext);
        end
    end

endmodule

// ===== rtl/mpct_checker.sv =====
// Port-level checks for the mouse packet cursor tracker, bound to the top level.
// Depends on mpct_pkg and mouse_packet_cursor_tracker_core.

module mpct_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mpct_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Fill bits above the fields stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[mpct_pkg::OUT_DATA_W-1:mpct_pkg::OUT_FIELDS_W] == '0)
        else $error("fill bits of result beat not zero");

    // A fresh result is checked against an earlier accepted byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result beat without a byte accepted two cycles before");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output was free");

endmodule

bind mouse_packet_cursor_tracker_core mpct_checker u_mpct_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
